>>> rtl/core/srev_pkg.sv
// shared constants, types and saturation helpers for the schroeder reverb unit
package srev_pkg;

  // audio format and internal word
  localparam int SAMPLE_RATE = 48000;
  localparam int SAMPLE_W    = 16;
  localparam int INT_W       = 24;
  localparam int COEF_W      = 16;
  localparam int EXT_W       = INT_W + 3;
  localparam int Q_W         = INT_W + 1;
  localparam int PROD_W      = INT_W + COEF_W + 1;
  localparam int ROUND_HALF  = 2 ** (COEF_W - 1);
  localparam int FB_GAIN     = 45875;

  // delay line lengths in samples
  localparam int C0 = (SAMPLE_RATE * 1) / 100;
  localparam int C1 = (SAMPLE_RATE * 12) / 100;
  localparam int C2 = (SAMPLE_RATE * 23) / 100;
  localparam int C3 = (SAMPLE_RATE * 34) / 100;
  localparam int C4 = (SAMPLE_RATE * 45) / 100;
  localparam int C5 = (SAMPLE_RATE * 56) / 100;
  localparam int A0 = (SAMPLE_RATE * 12) / 1000;
  localparam int A1 = (SAMPLE_RATE * 23) / 1000;

  localparam int COMB_TOTAL = C0 + C1 + C2 + C3 + C4 + C5;
  localparam int AP_TOTAL   = A0 + A1;
  localparam int COMB_AW    = $clog2(COMB_TOTAL);
  localparam int AP_AW      = $clog2(AP_TOTAL);
  localparam int POS_W      = $clog2(C5 + 1);
  localparam int NUM_LINES  = 8;
  localparam int LINE_W     = $clog2(NUM_LINES);
  localparam int LAST_COMB  = 5;
  localparam int LAST_AP    = 7;

  // combs first, then the two allpass lines; allpass bases are within their own store
  localparam int LINE_LEN [NUM_LINES] = '{C0, C1, C2, C3, C4, C5, A0, A1};
  localparam int LINE_BASE [NUM_LINES] = '{0, C0, C0 + C1, C0 + C1 + C2,
                                           C0 + C1 + C2 + C3,
                                           C0 + C1 + C2 + C3 + C4, 0, A0};

  // register defaults
  localparam logic [COEF_W-1:0] GAIN_RESET  = 16'd19661;
  localparam logic [COEF_W-1:0] ALPHA_RESET = 16'd32768;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_ALLPASS_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LPF_ALPHA    = 2'd1;

  localparam int INT_MAX = 2 ** (INT_W - 1) - 1;
  localparam int INT_MIN = -(2 ** (INT_W - 1));
  localparam int OUT_MAX = 2 ** (SAMPLE_W - 1) - 1;
  localparam int OUT_MIN = -(2 ** (SAMPLE_W - 1));

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_COMB_RD,
    S_COMB_MUL,
    S_COMB_ACC,
    S_AP_RD,
    S_AP_MUL_IN,
    S_AP_MUL_OUT,
    S_AP_MUL_G,
    S_AP_WRITE,
    S_LP_MUL_S,
    S_LP_MUL_X,
    S_LP_ADD,
    S_FINISH
  } state_t;

  // clamp a widened sum to the internal word
  function automatic logic signed [INT_W-1:0] sat_int(input logic signed [EXT_W-1:0] v);
    logic signed [INT_W-1:0] res;
    if (v > EXT_W'(INT_MAX)) begin
      res = INT_W'(INT_MAX);
    end else if (v < EXT_W'(INT_MIN)) begin
      res = INT_W'(INT_MIN);
    end else begin
      res = v[INT_W-1:0];
    end
    return res;
  endfunction

  // clamp a widened sum to the sample range
  function automatic logic signed [SAMPLE_W-1:0] sat_out(input logic signed [INT_W:0] v);
    logic signed [SAMPLE_W-1:0] res;
    if (v > (INT_W + 1)'(OUT_MAX)) begin
      res = SAMPLE_W'(OUT_MAX);
    end else if (v < (INT_W + 1)'(OUT_MIN)) begin
      res = SAMPLE_W'(OUT_MIN);
    end else begin
      res = v[SAMPLE_W-1:0];
    end
    return res;
  endfunction

endpackage

>>> rtl/core/schroeder_reverb_unit.sv
// schroeder reverberator: six combs, two allpass stages and a twice-run low-pass
//
// One 16-bit sample in, one 16-bit sample out. After reset the unit sweeps both
// delay stores to zero, one entry a cycle, across the length of the comb store;
// in_ready stays low during that sweep, while configuration writes are taken
// throughout. From the input transfer to the output register load, each sample
// takes a read, a multiply and an accumulate per comb line and a read, a chain of
// multiplies ending with the gain and a write per allpass stage, set by the
// single read and single write port of each delay store and by one shared 24x17
// multiplier, then the two low-pass passes and a finishing step. in_ready returns
// only once the previous sample is through, but a new sample is accepted while
// the previous result still waits in the output register; the finishing step
// holds until that register is free. The comb store is 82080 x 24 bit and the
// allpass store 1680 x 48 bit (input and output history side by side); both are
// read-modify-written one line at a time, so no two accesses to an entry overlap.
// allpass_gain (index 0) and lpf_alpha (index 1) are Q0.16 and should be written
// only while the unit is idle; writes to other indexes are dropped.
module schroeder_reverb_unit (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  logic signed [srev_pkg::SAMPLE_W-1:0]     in_sample,
  output logic                                     out_valid,
  input  logic                                     out_ready,
  output logic signed [srev_pkg::SAMPLE_W-1:0]     out_sample,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [srev_pkg::CFG_IDX_W-1:0]           cfg_index,
  input  logic [srev_pkg::COEF_W-1:0]              cfg_data
);

  // control state
  srev_pkg::state_t state, state_next;
  logic [srev_pkg::LINE_W-1:0]  li;
  logic                         lp_pass;
  logic [srev_pkg::COMB_AW-1:0] clr_cnt;
  logic [srev_pkg::POS_W-1:0]   pos [srev_pkg::NUM_LINES];

  // configuration
  logic [srev_pkg::COEF_W-1:0] allpass_gain;
  logic [srev_pkg::COEF_W-1:0] lpf_alpha;

  // datapath registers
  logic signed [srev_pkg::INT_W-1:0]  x;
  logic signed [srev_pkg::INT_W-1:0]  sig;
  logic signed [srev_pkg::INT_W-1:0]  tmp;
  logic signed [srev_pkg::Q_W-1:0]    hold;
  logic signed [srev_pkg::INT_W-1:0]  lp;
  logic signed [srev_pkg::PROD_W-1:0] prod;

  // delay stores
  logic signed [srev_pkg::INT_W-1:0] comb_mem [0:srev_pkg::COMB_TOTAL-1];
  logic [2*srev_pkg::INT_W-1:0]      ap_mem   [0:srev_pkg::AP_TOTAL-1];
  logic signed [srev_pkg::INT_W-1:0] comb_rdata;
  logic [2*srev_pkg::INT_W-1:0]      ap_rdata;

  // combinational datapath
  logic [srev_pkg::POS_W-1:0]         line_pos;
  logic [srev_pkg::POS_W-1:0]         pos_inc;
  logic [srev_pkg::POS_W-1:0]         pos_next;
  logic [srev_pkg::COMB_AW-1:0]       line_addr;
  logic signed [srev_pkg::PROD_W-1:0] rnd;
  logic signed [srev_pkg::Q_W-1:0]    q;
  logic signed [srev_pkg::INT_W-1:0]  ap_in_old;
  logic signed [srev_pkg::INT_W-1:0]  ap_out_old;
  logic signed [srev_pkg::INT_W-1:0]  comb_y;
  logic signed [srev_pkg::INT_W-1:0]  ap_y;
  logic signed [srev_pkg::INT_W-1:0]  mul_a;
  logic [srev_pkg::COEF_W:0]          mul_b;
  logic                               comb_we;
  logic [srev_pkg::COMB_AW-1:0]       comb_waddr;
  logic signed [srev_pkg::INT_W-1:0]  comb_wdata;
  logic                               ap_we;
  logic [srev_pkg::AP_AW-1:0]         ap_waddr;
  logic [2*srev_pkg::INT_W-1:0]       ap_wdata;
  logic                               fin_load;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == srev_pkg::S_IDLE);
  assign fin_load  = (state == srev_pkg::S_FINISH) && (!out_valid || out_ready);

  // current line position and its store address
  assign line_pos  = pos[li];
  assign pos_inc   = line_pos + srev_pkg::POS_W'(1);
  assign pos_next  = (pos_inc == srev_pkg::POS_W'(srev_pkg::LINE_LEN[li])) ? '0 : pos_inc;
  assign line_addr = srev_pkg::COMB_AW'(srev_pkg::LINE_BASE[li])
                   + srev_pkg::COMB_AW'(line_pos);

  // Q0.16 product rounded half up, i.e. floor((p + 0.5 lsb) / 2^16)
  assign rnd = prod + srev_pkg::PROD_W'(srev_pkg::ROUND_HALF);
  assign q   = rnd[srev_pkg::PROD_W-1:srev_pkg::COEF_W];

  // allpass store: input history in the upper half, output history in the lower
  assign ap_in_old  = ap_rdata[2*srev_pkg::INT_W-1:srev_pkg::INT_W];
  assign ap_out_old = ap_rdata[srev_pkg::INT_W-1:0];

  assign comb_y = srev_pkg::sat_int(srev_pkg::EXT_W'(x) + srev_pkg::EXT_W'(q));
  assign ap_y   = srev_pkg::sat_int(srev_pkg::EXT_W'(q) + srev_pkg::EXT_W'(hold));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srev_pkg::S_CLEAR: begin
        if (clr_cnt == srev_pkg::COMB_AW'(srev_pkg::COMB_TOTAL - 1)) begin
          state_next = srev_pkg::S_IDLE;
        end
      end
      srev_pkg::S_IDLE: begin
        if (in_valid) begin
          state_next = srev_pkg::S_COMB_RD;
        end
      end
      srev_pkg::S_COMB_RD:  state_next = srev_pkg::S_COMB_MUL;
      srev_pkg::S_COMB_MUL: state_next = srev_pkg::S_COMB_ACC;
      srev_pkg::S_COMB_ACC: begin
        if (li == srev_pkg::LINE_W'(srev_pkg::LAST_COMB)) begin
          state_next = srev_pkg::S_AP_RD;
        end else begin
          state_next = srev_pkg::S_COMB_RD;
        end
      end
      srev_pkg::S_AP_RD:      state_next = srev_pkg::S_AP_MUL_IN;
      srev_pkg::S_AP_MUL_IN:  state_next = srev_pkg::S_AP_MUL_OUT;
      srev_pkg::S_AP_MUL_OUT: state_next = srev_pkg::S_AP_MUL_G;
      srev_pkg::S_AP_MUL_G:   state_next = srev_pkg::S_AP_WRITE;
      srev_pkg::S_AP_WRITE: begin
        if (li == srev_pkg::LINE_W'(srev_pkg::LAST_AP)) begin
          state_next = srev_pkg::S_LP_MUL_S;
        end else begin
          state_next = srev_pkg::S_AP_RD;
        end
      end
      srev_pkg::S_LP_MUL_S: state_next = srev_pkg::S_LP_MUL_X;
      srev_pkg::S_LP_MUL_X: state_next = srev_pkg::S_LP_ADD;
      srev_pkg::S_LP_ADD: begin
        if (lp_pass) begin
          state_next = srev_pkg::S_FINISH;
        end else begin
          state_next = srev_pkg::S_LP_MUL_S;
        end
      end
      srev_pkg::S_FINISH: begin
        if (fin_load) begin
          state_next = srev_pkg::S_IDLE;
        end
      end
      default: state_next = srev_pkg::S_CLEAR;
    endcase
  end

  // multiplier operands and store writes
  always_comb begin
    mul_a      = comb_rdata;
    mul_b      = (srev_pkg::COEF_W + 1)'(srev_pkg::FB_GAIN);
    comb_we    = 1'b0;
    comb_waddr = line_addr;
    comb_wdata = comb_y;
    ap_we      = 1'b0;
    ap_waddr   = line_addr[srev_pkg::AP_AW-1:0];
    ap_wdata   = {sig, ap_y};
    case (state)
      srev_pkg::S_CLEAR: begin
        comb_we    = 1'b1;
        comb_waddr = clr_cnt;
        comb_wdata = '0;
        ap_we      = (clr_cnt < srev_pkg::COMB_AW'(srev_pkg::AP_TOTAL));
        ap_waddr   = clr_cnt[srev_pkg::AP_AW-1:0];
        ap_wdata   = '0;
      end
      srev_pkg::S_COMB_ACC: comb_we = 1'b1;
      srev_pkg::S_AP_MUL_IN: mul_a = sig;
      srev_pkg::S_AP_MUL_OUT: mul_a = ap_out_old;
      srev_pkg::S_AP_MUL_G: begin
        mul_a = tmp;
        mul_b = {1'b0, allpass_gain};
      end
      srev_pkg::S_AP_WRITE: ap_we = 1'b1;
      srev_pkg::S_LP_MUL_S: begin
        mul_a = lp;
        mul_b = (srev_pkg::COEF_W + 1)'(2 ** srev_pkg::COEF_W) - {1'b0, lpf_alpha};
      end
      srev_pkg::S_LP_MUL_X: begin
        mul_a = sig;
        mul_b = {1'b0, lpf_alpha};
      end
      default: ;
    endcase
  end

  // delay stores, one write and one registered read port each
  always_ff @(posedge clk) begin
    if (comb_we) begin
      comb_mem[comb_waddr] <= comb_wdata;
    end
    comb_rdata <= comb_mem[line_addr];
  end

  always_ff @(posedge clk) begin
    if (ap_we) begin
      ap_mem[ap_waddr] <= ap_wdata;
    end
    ap_rdata <= ap_mem[line_addr[srev_pkg::AP_AW-1:0]];
  end

  // shared multiplier, registered
  always_ff @(posedge clk) begin
    prod <= srev_pkg::PROD_W'(mul_a * $signed({1'b0, mul_b}));
  end

  // control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srev_pkg::S_CLEAR;
      clr_cnt      <= '0;
      li           <= '0;
      lp_pass      <= 1'b0;
      lp           <= '0;
      out_valid    <= 1'b0;
      allpass_gain <= srev_pkg::GAIN_RESET;
      lpf_alpha    <= srev_pkg::ALPHA_RESET;
      for (int i = 0; i < srev_pkg::NUM_LINES; i++) begin
        pos[i] <= '0;
      end
    end else begin
      state <= state_next;

      // register writes
      if (cfg_valid) begin
        case (cfg_index)
          srev_pkg::REG_ALLPASS_GAIN: allpass_gain <= cfg_data;
          srev_pkg::REG_LPF_ALPHA:    lpf_alpha    <= cfg_data;
          default: ;
        endcase
      end

      // output register empties on a transfer unless a new result lands at once
      if (out_valid && out_ready && !fin_load) begin
        out_valid <= 1'b0;
      end

      case (state)
        srev_pkg::S_CLEAR: clr_cnt <= clr_cnt + srev_pkg::COMB_AW'(1);
        srev_pkg::S_IDLE: begin
          if (in_valid) begin
            x   <= srev_pkg::INT_W'(in_sample);
            sig <= '0;
            li  <= '0;
          end
        end
        srev_pkg::S_COMB_ACC: begin
          // comb sum accumulates into sig
          sig     <= srev_pkg::sat_int(srev_pkg::EXT_W'(sig) + srev_pkg::EXT_W'(comb_y));
          pos[li] <= pos_next;
          li      <= li + srev_pkg::LINE_W'(1);
        end
        srev_pkg::S_AP_MUL_OUT: begin
          tmp <= srev_pkg::sat_int(srev_pkg::EXT_W'(q) - srev_pkg::EXT_W'(ap_in_old));
        end
        srev_pkg::S_AP_MUL_G: hold <= q;
        srev_pkg::S_AP_WRITE: begin
          sig     <= ap_y;
          pos[li] <= pos_next;
          li      <= li + srev_pkg::LINE_W'(1);
          lp_pass <= 1'b0;
        end
        srev_pkg::S_LP_MUL_X: hold <= q;
        srev_pkg::S_LP_ADD: begin
          lp      <= ap_y;
          lp_pass <= 1'b1;
        end
        srev_pkg::S_FINISH: begin
          if (fin_load) begin
            out_sample <= srev_pkg::sat_out((srev_pkg::INT_W + 1)'(x)
                                            + (srev_pkg::INT_W + 1)'(lp));
            out_valid  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // a result only appears straight after the finishing step
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == srev_pkg::S_FINISH)
    else $error("result raised outside the finishing step");

  // an accepted sample starts the first comb read
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == srev_pkg::S_COMB_RD && li == '0)
    else $error("accepted sample did not start the comb sequence");

  // the selected line position never reaches its line length
  assert property (@(posedge clk) disable iff (rst)
    line_pos < srev_pkg::POS_W'(srev_pkg::LINE_LEN[li]))
    else $error("line position out of range");

  // no store is written while waiting for a sample
  assert property (@(posedge clk) disable iff (rst)
    state == srev_pkg::S_IDLE |-> !comb_we && !ap_we)
    else $error("delay store written while idle");

  // the input stays closed and no result is valid until the clearing sweep has finished
  assert property (@(posedge clk) disable iff (rst)
    state == srev_pkg::S_CLEAR |-> !in_ready && !out_valid)
    else $error("activity during the clearing sweep");

endmodule
